// ===== hdl/pin_report_message_parser_core_defines.svh =====
// Assertion macros for the pin report message parser.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef PIN_REPORT_MESSAGE_PARSER_CORE_DEFINES_SVH
`define PIN_REPORT_MESSAGE_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PRMP_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRMP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PRMP_ASSERT_IMPL(label, clk, rst, prop, msg)
`define PRMP_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/prmp_pkg.sv =====
// Shared types and constants for the pin report message parser.
// No dependencies; used by prmp_pair_eval and pin_report_message_parser_core.
package prmp_pkg;

   localparam int NUM_PORTS_P     = 16;
   localparam int BITS_PER_PORT_P = 16;
   localparam int MAX_PINS        = 64;

   // effective key limits (the result fields cap them at 64 / 16 / 16)
   localparam int PinLimit  = (MAX_PINS < 64) ? MAX_PINS : 64;
   localparam int PortLimit = (NUM_PORTS_P < 16) ? NUM_PORTS_P : 16;
   localparam int BitLimit  = (BITS_PER_PORT_P < 16) ? BITS_PER_PORT_P : 16;

   localparam logic [7:0] CH_OPEN  = 8'h7B; // {
   localparam logic [7:0] CH_CLOSE = 8'h7D; // }
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_NO_CLOSE  = 3'd1;
   localparam logic [2:0] ERR_NO_COLON  = 3'd2;
   localparam logic [2:0] ERR_KEY_RANGE = 3'd3;
   localparam logic [2:0] ERR_IGNORED   = 3'd4;

   localparam logic [1:0] CSR_EVENT   = 2'd0;
   localparam logic [1:0] CSR_SERVICE = 2'd1;
   localparam logic [1:0] CSR_MAP_TAG = 2'd2;
   localparam logic [1:0] CSR_ANA_TAG = 2'd3;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_ANALOG,
      MODE_MAP
   } mode_type;

   typedef struct packed {
      logic [7:0]  key_acc;
      logic [15:0] value_acc;
      logic        saw_colon;
      logic        number_stopped;
      logic        value_over;
      logic        token_open;
   } pair_type;

   typedef struct packed {
      logic        has_entry;
      logic        kind;
      logic [5:0]  pin;
      logic [15:0] pin_value;
      logic [3:0]  port;
      logic [3:0]  bit_index;
      logic        list_end;
      logic [2:0]  error;
   } rsp_type;

endpackage

// ===== hdl/prmp_pair_eval.sv =====
// Closes a pending key:value pair and forms its response.
// Depends on prmp_pkg.
module prmp_pair_eval (
   input  prmp_pkg::mode_type mode,
   input  prmp_pkg::pair_type pair,
   input  logic [7:0]         pair_count,
   output prmp_pkg::rsp_type  rsp
);

   logic [4:0] bit_idx;

   // floor log2 of the mask; a mask past 16 bits counts as 16
   always_comb begin
      bit_idx = 5'd0;
      for (int i = 1; i < 16; i++) begin
         if (pair.value_acc[i]) bit_idx = 5'(i);
      end
      if (pair.value_over) bit_idx = 5'd16;
   end

   always_comb begin
      rsp      = '0;
      rsp.kind = (mode == prmp_pkg::MODE_MAP);
      if (!pair.saw_colon) begin
         rsp.error = prmp_pkg::ERR_NO_COLON;
      end else if (mode == prmp_pkg::MODE_ANALOG) begin
         if (9'(pair.key_acc) >= 9'(prmp_pkg::PinLimit)) begin
            rsp.error = prmp_pkg::ERR_KEY_RANGE;
         end else begin
            rsp.has_entry = 1'b1;
            rsp.pin       = pair.key_acc[5:0];
            rsp.pin_value = pair.value_acc;
         end
      end else begin
         if (9'(pair.key_acc) >= 9'(prmp_pkg::PortLimit) ||
             bit_idx >= 5'(prmp_pkg::BitLimit) ||
             9'(pair_count) >= 9'(prmp_pkg::PinLimit)) begin
            rsp.error = prmp_pkg::ERR_KEY_RANGE;
         end else begin
            rsp.has_entry = 1'b1;
            rsp.pin       = pair_count[5:0];
            rsp.port      = pair.key_acc[3:0];
            rsp.bit_index = bit_idx[3:0];
         end
      end
   end

endmodule

// ===== hdl/pin_report_message_parser_core.sv =====
// Pin report message parser top level: header check, pair parsing, response register.
// Depends on prmp_pkg, prmp_pair_eval and pin_report_message_parser_core_defines.svh.
//
//   channel   dir  handshake          payload
//   req_      in   tvalid/tready      tdata = ch, tlast = last of message
//   rsp_      out  tvalid/tready      tdata = pin..bit_index, tuser = flags, tlast = list_end
//   csr_      in   we                 addr = register index, wdata = value
//
// One character per cycle while req_tready is high; each request updates the parse state in the cycle it is accepted.
// A response is registered in the cycle after its request is accepted and sits in a single output register.
// req_tready stays high while that register is empty or being drained.
// Synchronous active-high reset restores all registers but rsp_ff and returns to header position zero.
`include "pin_report_message_parser_core_defines.svh"
module pin_report_message_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [5:0] pin, [21:6] pin_value, [25:22] port,
                                    // [29:26] bit_index, [31:30] zero
   output logic [4:0]  rsp_tuser,   // [0] has_entry, [1] kind, [4:2] error
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_SEEK,
      PH_LIST,
      PH_DONE,
      PH_IGNORE
   } phase_type;

   phase_type          phase_ff, phase_in;
   prmp_pkg::mode_type mode_ff, mode_in;
   prmp_pkg::pair_type pair_ff, pair_in;
   logic [7:0]         pair_count_ff, pair_count_in;
   logic [7:0]         event_char_ff, service_char_ff, map_tag_ff, ana_tag_ff;
   prmp_pkg::rsp_type  rsp_ff, rsp_in, pair_rsp;
   logic               rsp_valid_ff, rsp_fire;
   logic               accept;

   logic [7:0]  ch;
   logic        is_dec;
   logic [3:0]  dec_val;
   logic        is_hex;
   logic [3:0]  hex_val;
   logic [11:0] key_mac;
   logic [19:0] val_mac;

   assign ch         = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_dec  = (ch >= prmp_pkg::CH_ZERO) && (ch <= prmp_pkg::CH_NINE);
   assign dec_val = 4'(ch - prmp_pkg::CH_ZERO);
   assign key_mac = 12'(pair_ff.key_acc) * 12'd10 + 12'(dec_val);
   assign val_mac = 20'(pair_ff.value_acc) * 20'd10 + 20'(dec_val);

   always_comb begin
      is_hex  = 1'b1;
      hex_val = dec_val;
      if (ch >= prmp_pkg::CH_LA && ch <= prmp_pkg::CH_LF) begin
         hex_val = 4'(ch - prmp_pkg::CH_LA + 8'd10);
      end else if (ch >= prmp_pkg::CH_UA && ch <= prmp_pkg::CH_UF) begin
         hex_val = 4'(ch - prmp_pkg::CH_UA + 8'd10);
      end else if (!is_dec) begin
         is_hex = 1'b0;
      end
   end

   prmp_pair_eval u_pair_eval (
      .mode       (mode_ff),
      .pair       (pair_ff),
      .pair_count (pair_count_ff),
      .rsp        (pair_rsp)
   );

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      pair_in       = pair_ff;
      pair_count_in = pair_count_ff;
      rsp_in        = '0;
      rsp_fire      = 1'b0;

      unique case (phase_ff)
         PH_HDR0: phase_in = (ch == event_char_ff) ? PH_HDR1 : PH_IGNORE;
         PH_HDR1: phase_in = (ch == service_char_ff) ? PH_HDR2 : PH_IGNORE;
         PH_HDR2: phase_in = PH_HDR3;
         PH_HDR3: begin
            if (ch == map_tag_ff) begin
               mode_in  = prmp_pkg::MODE_MAP;
               phase_in = PH_SEEK;
            end else if (ch == ana_tag_ff) begin
               mode_in  = prmp_pkg::MODE_ANALOG;
               phase_in = PH_SEEK;
            end else begin
               phase_in = PH_IGNORE;
            end
         end
         PH_SEEK: begin
            if (ch == prmp_pkg::CH_OPEN) begin
               phase_in = PH_LIST;
               pair_in  = '0;
            end
         end
         PH_LIST: begin
            if (ch == prmp_pkg::CH_COMMA || ch == prmp_pkg::CH_CLOSE) begin
               if (pair_ff.token_open) begin
                  rsp_in  = pair_rsp;
                  pair_in = '0;
                  if (mode_ff == prmp_pkg::MODE_MAP && pair_count_ff != 8'hFF) begin
                     pair_count_in = pair_count_ff + 8'd1;
                  end
                  rsp_fire = 1'b1;
               end else begin
                  rsp_in.kind = (mode_ff == prmp_pkg::MODE_MAP);
               end
               if (ch == prmp_pkg::CH_CLOSE) begin
                  rsp_in.list_end = 1'b1;
                  rsp_fire        = 1'b1;
                  phase_in        = PH_DONE;
               end
            end else if (ch == prmp_pkg::CH_COLON) begin
               pair_in.token_open = 1'b1;
               if (!pair_ff.saw_colon) begin
                  pair_in.saw_colon      = 1'b1;
                  pair_in.number_stopped = 1'b0;
                  pair_in.value_acc      = '0;
                  pair_in.value_over     = 1'b0;
               end else begin
                  pair_in.number_stopped = 1'b1;
               end
            end else begin
               pair_in.token_open = 1'b1;
               if (!pair_ff.number_stopped) begin
                  if (!pair_ff.saw_colon) begin
                     if (is_dec) begin
                        pair_in.key_acc = (key_mac > 12'd255) ? 8'hFF : key_mac[7:0];
                     end else begin
                        pair_in.number_stopped = 1'b1;
                     end
                  end else if (mode_ff == prmp_pkg::MODE_ANALOG) begin
                     if (is_dec) begin
                        pair_in.value_acc = (val_mac > 20'd65535) ? 16'hFFFF : val_mac[15:0];
                     end else begin
                        pair_in.number_stopped = 1'b1;
                     end
                  end else begin
                     if (!is_hex) begin
                        pair_in.number_stopped = 1'b1;
                     end else if (pair_ff.value_over || pair_ff.value_acc > 16'h0FFF) begin
                        pair_in.value_over = 1'b1;
                        pair_in.value_acc  = 16'hFFFF;
                     end else begin
                        pair_in.value_acc = {pair_ff.value_acc[11:0], hex_val};
                     end
                  end
               end
            end
         end
         PH_DONE, PH_IGNORE: ;
         default: ;
      endcase

      if (req_tlast) begin
         if (phase_in == PH_SEEK || phase_in == PH_LIST) begin
            rsp_in       = '0;
            rsp_in.error = prmp_pkg::ERR_NO_CLOSE;
            rsp_fire     = 1'b1;
         end else if (phase_in != PH_DONE) begin
            rsp_in       = '0;
            rsp_in.error = prmp_pkg::ERR_IGNORED;
            rsp_fire     = 1'b1;
         end
         phase_in      = PH_HDR0;
         mode_in       = prmp_pkg::MODE_NONE;
         pair_count_in = '0;
         pair_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         mode_ff         <= prmp_pkg::MODE_NONE;
         pair_ff         <= '0;
         pair_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         event_char_ff   <= 8'd64;
         service_char_ff <= 8'd73;
         map_tag_ff      <= 8'd77;
         ana_tag_ff      <= 8'd97;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               prmp_pkg::CSR_EVENT:   event_char_ff   <= csr_wdata;
               prmp_pkg::CSR_SERVICE: service_char_ff <= csr_wdata;
               prmp_pkg::CSR_MAP_TAG: map_tag_ff      <= csr_wdata;
               prmp_pkg::CSR_ANA_TAG: ana_tag_ff      <= csr_wdata;
               default: ;
            endcase
         end
         rsp_valid_ff <= (accept && rsp_fire) || (rsp_valid_ff && !rsp_tready);
         if (accept) begin
            phase_ff      <= phase_in;
            mode_ff       <= mode_in;
            pair_ff       <= pair_in;
            pair_count_ff <= pair_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.bit_index, rsp_ff.port, rsp_ff.pin_value, rsp_ff.pin};
   assign rsp_tuser  = {rsp_ff.error, rsp_ff.kind, rsp_ff.has_entry};
   assign rsp_tlast  = rsp_ff.list_end;

   `PRMP_ASSERT_IMPL(a_entry_no_error, clock, reset,
      rsp_valid_ff && rsp_ff.has_entry |-> rsp_ff.error == prmp_pkg::ERR_OK,
      "parsed entry carries an error code")
   `PRMP_ASSERT_IMPL(a_list_end_ok, clock, reset,
      rsp_valid_ff && rsp_ff.list_end |-> rsp_ff.error == prmp_pkg::ERR_OK ||
      rsp_ff.error == prmp_pkg::ERR_NO_COLON || rsp_ff.error == prmp_pkg::ERR_KEY_RANGE,
      "list end response with message-level error")
   `PRMP_ASSERT_IMPL(a_msg_restart, clock, reset,
      accept && req_tlast |=> phase_ff == PH_HDR0 && pair_count_ff == 8'd0 &&
      mode_ff == prmp_pkg::MODE_NONE,
      "parser did not return to header after last character")
   `PRMP_ASSERT_NEVER(a_list_needs_mode, clock, reset,
      (phase_ff == PH_SEEK || phase_ff == PH_LIST || phase_ff == PH_DONE) &&
      mode_ff == prmp_pkg::MODE_NONE,
      "pair list reached without a mode")
   `PRMP_ASSERT_IMPL(a_hold_stalled, clock, reset,
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff),
      "stalled response changed")

endmodule

// ===== sim/pin_report_message_parser_core_tb.sv =====
// Testbench for pin_report_message_parser_core: directed table, then random messages.
// Carries its own parser predictor and scoreboard; depends only on prmp_pkg and the RTL.
module pin_report_message_parser_core_tb;

   localparam int WATCHDOG_LIMIT        = 2000;
   localparam int LONG_HOLD             = 64;
   localparam prmp_pkg::rsp_type NO_RSP = '0;

   typedef enum logic [2:0] {
      HDR_EVENT, HDR_SERVICE, HDR_SKIP, HDR_TAG, SEEK_OPEN, IN_LIST, LIST_DONE, IGNORING
   } parse_phase_type;

   typedef struct packed {
      logic [7:0]        ch;
      logic              last;
      logic              fixed;
      prmp_pkg::rsp_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   // request annotation for the directed table
   logic              row_fixed = 1'b0;
   prmp_pkg::rsp_type row_want = '0;

   // predictor state
   logic [7:0]         cfg_event, cfg_service, cfg_map_tag, cfg_ana_tag;
   parse_phase_type    ph;
   prmp_pkg::mode_type pmode;
   int unsigned        key_acc, value_acc, pin_count;
   bit                 saw_colon, num_stopped, mask_over, token_open;

   prmp_pkg::rsp_type  pending_rsp_q[$];
   dir_row_type        dir_rows[$];
   logic [7:0]         msg_q[$];

   int unsigned  sent_count, rsp_count, entry_count, flagged_count, fail_count;
   int unsigned  idle_pct;
   bit           long_hold_done;

   pin_report_message_parser_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void clear_pair();
      key_acc = 0;
      value_acc = 0;
      saw_colon = 1'b0;
      num_stopped = 1'b0;
      mask_over = 1'b0;
      token_open = 1'b0;
   endfunction

   function automatic void clear_message();
      ph = HDR_EVENT;
      pmode = prmp_pkg::MODE_NONE;
      pin_count = 0;
      clear_pair();
   endfunction

   function automatic prmp_pkg::rsp_type close_pair();
      prmp_pkg::rsp_type r;
      int unsigned       bi, v;
      r = '0;
      r.kind = (pmode == prmp_pkg::MODE_MAP);
      if (!saw_colon) begin
         r.error = prmp_pkg::ERR_NO_COLON;
      end else if (pmode == prmp_pkg::MODE_ANALOG) begin
         if (key_acc >= prmp_pkg::PinLimit) begin
            r.error = prmp_pkg::ERR_KEY_RANGE;
         end else begin
            r.has_entry = 1'b1;
            r.pin = key_acc[5:0];
            r.pin_value = value_acc[15:0];
         end
      end else begin
         bi = 0;
         v = value_acc;
         while (v > 1) begin
            v = v >> 1;
            bi++;
         end
         if (mask_over) bi = 16;
         if (key_acc >= prmp_pkg::PortLimit || bi >= prmp_pkg::BitLimit ||
             pin_count >= prmp_pkg::PinLimit) begin
            r.error = prmp_pkg::ERR_KEY_RANGE;
         end else begin
            r.has_entry = 1'b1;
            r.pin = pin_count[5:0];
            r.port = key_acc[3:0];
            r.bit_index = bi[3:0];
         end
      end
      if (pmode == prmp_pkg::MODE_MAP && pin_count < 255) pin_count++;
      clear_pair();
      return r;
   endfunction

   // advances the parse state by one character; returns 1 when a response is due
   function automatic bit parse_char(input logic [7:0] c, input logic last,
                                     output prmp_pkg::rsp_type r);
      bit hit;
      int d;
      hit = 1'b0;
      r = '0;
      case (ph)
         HDR_EVENT:   ph = (c == cfg_event) ? HDR_SERVICE : IGNORING;
         HDR_SERVICE: ph = (c == cfg_service) ? HDR_SKIP : IGNORING;
         HDR_SKIP:    ph = HDR_TAG;
         HDR_TAG: begin
            if (c == cfg_map_tag) begin
               pmode = prmp_pkg::MODE_MAP;
               ph = SEEK_OPEN;
            end else if (c == cfg_ana_tag) begin
               pmode = prmp_pkg::MODE_ANALOG;
               ph = SEEK_OPEN;
            end else begin
               ph = IGNORING;
            end
         end
         SEEK_OPEN: begin
            if (c == prmp_pkg::CH_OPEN) begin
               ph = IN_LIST;
               clear_pair();
            end
         end
         IN_LIST: begin
            if (c == prmp_pkg::CH_COMMA) begin
               if (token_open) begin
                  r = close_pair();
                  hit = 1'b1;
               end
            end else if (c == prmp_pkg::CH_CLOSE) begin
               if (token_open) r = close_pair();
               else r.kind = (pmode == prmp_pkg::MODE_MAP);
               r.list_end = 1'b1;
               hit = 1'b1;
               ph = LIST_DONE;
            end else if (c == prmp_pkg::CH_COLON) begin
               token_open = 1'b1;
               if (!saw_colon) begin
                  saw_colon = 1'b1;
                  num_stopped = 1'b0;
                  value_acc = 0;
                  mask_over = 1'b0;
               end else begin
                  num_stopped = 1'b1;
               end
            end else begin
               token_open = 1'b1;
               d = -1;
               if (c >= prmp_pkg::CH_ZERO && c <= prmp_pkg::CH_NINE) begin
                  d = int'(c - prmp_pkg::CH_ZERO);
               end else if (pmode == prmp_pkg::MODE_MAP && saw_colon) begin
                  if (c >= prmp_pkg::CH_LA && c <= prmp_pkg::CH_LF)
                     d = int'(c - prmp_pkg::CH_LA) + 10;
                  else if (c >= prmp_pkg::CH_UA && c <= prmp_pkg::CH_UF)
                     d = int'(c - prmp_pkg::CH_UA) + 10;
               end
               if (num_stopped) begin
               end else if (d < 0) begin
                  num_stopped = 1'b1;
               end else if (!saw_colon) begin
                  key_acc = key_acc * 10 + d;
                  if (key_acc > 255) key_acc = 255;
               end else if (pmode == prmp_pkg::MODE_ANALOG) begin
                  value_acc = value_acc * 10 + d;
                  if (value_acc > 65535) value_acc = 65535;
               end else if (mask_over || value_acc > 'hFFF) begin
                  mask_over = 1'b1;
                  value_acc = 'hFFFF;
               end else begin
                  value_acc = (value_acc << 4) | d;
               end
            end
         end
         default: ;
      endcase
      if (last) begin
         if (ph == SEEK_OPEN || ph == IN_LIST) begin
            r = '0;
            r.error = prmp_pkg::ERR_NO_CLOSE;
            hit = 1'b1;
         end else if (ph != LIST_DONE) begin
            r = '0;
            r.error = prmp_pkg::ERR_IGNORED;
            hit = 1'b1;
         end
         clear_message();
      end
      return hit;
   endfunction

   function automatic prmp_pkg::rsp_type flag_rsp(logic kind, logic list_end, logic [2:0] err);
      prmp_pkg::rsp_type r;
      r = '0;
      r.kind = kind;
      r.list_end = list_end;
      r.error = err;
      return r;
   endfunction

   function automatic string rsp_text(prmp_pkg::rsp_type r);
      return $sformatf("entry=%0b kind=%0b pin=%0d value=%0d port=%0d bit=%0d end=%0b err=%0d",
                       r.has_entry, r.kind, r.pin, r.pin_value, r.port, r.bit_index,
                       r.list_end, r.error);
   endfunction

   // scoreboard, predictor update and watchdog
   always @(posedge clock) begin : monitor
      prmp_pkg::rsp_type got, want, predicted;
      bit                hit, progress;
      int unsigned       idle_cycles;
      if (reset) begin
         cfg_event = 8'd64;
         cfg_service = 8'd73;
         cfg_map_tag = 8'd77;
         cfg_ana_tag = 8'd97;
         clear_message();
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            got = '0;
            got.has_entry = rsp_tuser[0];
            got.kind = rsp_tuser[1];
            got.error = rsp_tuser[4:2];
            got.pin = rsp_tdata[5:0];
            got.pin_value = rsp_tdata[21:6];
            got.port = rsp_tdata[25:22];
            got.bit_index = rsp_tdata[29:26];
            got.list_end = rsp_tlast;
            rsp_count++;
            if (got.has_entry) entry_count++;
            if (got.error != prmp_pkg::ERR_OK) flagged_count++;
            if (pending_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 20)
                  $display("%0t unexpected response: expected none, got %s",
                           $time, rsp_text(got));
            end else begin
               want = pending_rsp_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 20)
                     $display("%0t mismatch: expected %s, got %s",
                              $time, rsp_text(want), rsp_text(got));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            progress = 1'b1;
            hit = parse_char(req_tdata, req_tlast, predicted);
            if (row_fixed) pending_rsp_q.push_back(row_want);
            else if (hit) pending_rsp_q.push_back(predicted);
         end
         if (csr_we) begin
            progress = 1'b1;
            case (csr_addr)
               prmp_pkg::CSR_EVENT:   cfg_event = csr_wdata;
               prmp_pkg::CSR_SERVICE: cfg_service = csr_wdata;
               prmp_pkg::CSR_MAP_TAG: cfg_map_tag = csr_wdata;
               prmp_pkg::CSR_ANA_TAG: cfg_ana_tag = csr_wdata;
               default: ;
            endcase
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t timeout: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // response side: random stalls plus one long hold-off while requests keep coming
   initial begin : rsp_drain
      forever begin
         @(negedge clock);
         if (!reset && !long_hold_done && idle_pct != 0 && rsp_count >= 40 && req_tvalid) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic last, input logic fixed,
                            input prmp_pkg::rsp_type want);
      int unsigned gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      row_fixed <= fixed;
      row_want <= want;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   function automatic void push_decimal(int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
   endfunction

   function automatic void add_pair(bit map_mode);
      int unsigned sel, ndig, d;
      sel = $urandom_range(0, 99);
      if (sel < 6) return;
      if (sel < 14) begin
      end else if (sel < 24) begin
         push_decimal($urandom_range(0, 2000));
      end else begin
         push_decimal(map_mode ? $urandom_range(0, 17) : $urandom_range(0, 66));
      end
      if ($urandom_range(0, 9) == 0) msg_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) return;
      msg_q.push_back(prmp_pkg::CH_COLON);
      if (map_mode) begin
         if ($urandom_range(0, 7) == 0) begin
            msg_q.push_back(prmp_pkg::CH_ZERO);
            msg_q.push_back("x");
         end
         ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
         repeat (ndig) begin
            d = $urandom_range(0, 15);
            if (d < 10) msg_q.push_back(8'(prmp_pkg::CH_ZERO + d));
            else msg_q.push_back(8'(($urandom_range(0, 1) ? prmp_pkg::CH_LA
                                                          : prmp_pkg::CH_UA) + d - 10));
         end
      end else if ($urandom_range(0, 9) != 0) begin
         push_decimal(($urandom_range(0, 7) == 0) ? $urandom_range(65000, 999999)
                                                  : $urandom_range(0, 4095));
      end
      if ($urandom_range(0, 9) == 0) begin
         msg_q.push_back($urandom_range(0, 1) ? prmp_pkg::CH_COLON
                                              : 8'($urandom_range(0, 255)));
         push_decimal($urandom_range(0, 99));
      end
   endfunction

   // mostly well-formed messages; some truncated, some with a bad header, some noise
   task automatic send_message(bit force_long);
      int unsigned shape, npairs, cut, idx;
      bit map_mode;
      msg_q.delete();
      shape = force_long ? 0 : $urandom_range(0, 99);
      if (shape >= 90) begin
         repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         map_mode = force_long || $urandom_range(0, 1);
         msg_q.push_back(cfg_event);
         msg_q.push_back(cfg_service);
         msg_q.push_back(8'($urandom_range(0, 255)));
         msg_q.push_back(map_mode ? cfg_map_tag : cfg_ana_tag);
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
            msg_q.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 19) != 0) msg_q.push_back(prmp_pkg::CH_OPEN);
         npairs = force_long ? 70 : $urandom_range(1, 5);
         for (int i = 0; i < npairs; i++) begin
            if (i != 0) msg_q.push_back(prmp_pkg::CH_COMMA);
            // short pairs without colon walk the running pin up quickly
            if (force_long && i < 56) push_decimal($urandom_range(0, 9));
            else add_pair(map_mode);
         end
         if (force_long || $urandom_range(0, 9) != 0) msg_q.push_back(prmp_pkg::CH_CLOSE);
         repeat ($urandom_range(0, 2)) msg_q.push_back(8'($urandom_range(0, 255)));
         if (shape >= 75 && shape < 85) begin
            cut = $urandom_range(1, msg_q.size());
            while (msg_q.size() > cut) void'(msg_q.pop_back());
         end else if (shape >= 85) begin
            idx = $urandom_range(0, 2);
            if (idx == 2) idx = 3;
            msg_q[idx] = 8'($urandom_range(0, 255));
         end
      end
      foreach (msg_q[i]) send_char(msg_q[i], i == msg_q.size() - 1, 1'b0, NO_RSP);
   endtask

   task automatic run_phase(int unsigned n_items, bit force_long);
      int unsigned start;
      start = sent_count;
      if (force_long) send_message(1'b1);
      while (sent_count - start < n_items) send_message(1'b0);
   endtask

   // drain before touching the registers
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(logic [7:0] ev, logic [7:0] svc, logic [7:0] mtag,
                                logic [7:0] atag);
      write_reg(prmp_pkg::CSR_EVENT, ev);
      write_reg(prmp_pkg::CSR_SERVICE, svc);
      write_reg(prmp_pkg::CSR_MAP_TAG, mtag);
      write_reg(prmp_pkg::CSR_ANA_TAG, atag);
   endtask

   initial begin : stimulus
      // single bytes at both extremes: too short, ignored
      dir_rows.push_back({8'hFF, 1'b1, 1'b1, flag_rsp(1'b0, 1'b0, prmp_pkg::ERR_IGNORED)});
      dir_rows.push_back({8'h00, 1'b1, 1'b1, flag_rsp(1'b0, 1'b0, prmp_pkg::ERR_IGNORED)});
      // analog: one pair, an empty pair, a pair without colon closed by the brace
      dir_rows.push_back({"@", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"I", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({" ", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"a", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"{", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"3", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({":", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"7", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({",", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({",", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"x", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"}", 1'b0, 1'b1, flag_rsp(1'b0, 1'b1, prmp_pkg::ERR_NO_COLON)});
      dir_rows.push_back({"!", 1'b1, 1'b0, NO_RSP});
      // mapping: one pair, then the message ends with the list still open
      dir_rows.push_back({"@", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"I", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"0", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"M", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"{", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"9", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({":", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"8", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({",", 1'b0, 1'b0, NO_RSP});
      dir_rows.push_back({"1", 1'b1, 1'b1, flag_rsp(1'b0, 1'b0, prmp_pkg::ERR_NO_CLOSE)});

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      idle_pct = 30;
      foreach (dir_rows[i])
         send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].fixed, dir_rows[i].want);
      run_phase(75, 1'b0);

      settle();
      apply_setting(8'h00, 8'hFF, 8'h00, 8'hFF);
      run_phase(0, 1'b1);

      settle();
      idle_pct = 0;
      apply_setting(8'hFF, 8'h00, "Z", "Z");
      run_phase(75, 1'b0);

      settle();
      idle_pct = 50;
      apply_setting("#", "S", "m", "A");
      run_phase(75, 1'b0);

      settle();
      idle_pct = 0;
      apply_setting(8'd64, 8'd73, 8'd77, 8'd97);
      run_phase(75, 1'b0);

      settle();
      repeat (8) @(negedge clock);
      $display("Run covered %0d requests and %0d responses (%0d pairs, %0d flagged)",
               sent_count, rsp_count, entry_count, flagged_count);
      $display("over five register settings; long output stall taken: %0b", long_hold_done);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/prmp_pkg.sv
hdl/prmp_pair_eval.sv
hdl/pin_report_message_parser_core.sv
sim/pin_report_message_parser_core_tb.sv
